@@ design/tce_pkg.sv @@
// ----------------------------------------------------------------------------
// tce_pkg: shared types and constants for the toy core instruction execute
// Widths, operation codes, flag positions and the result record that the
// execute logic hands to the output register.
// ----------------------------------------------------------------------------
package tce_pkg;

	// Datapath and program counter widths.
	localparam int DATA_WIDTH = 64;
	localparam int PC_WIDTH   = 32;

	// Register file geometry.
	localparam int NUM_REGS = 16;
	localparam int REG_IDX_W = $clog2(NUM_REGS);

	// Port widths fixed by the interface.
	localparam int INSTR_W       = 32;
	localparam int NEXT_PC_W     = 32;
	localparam int WRITE_VALUE_W = 64;
	localparam int FLAGS_W       = 7;
	localparam int BR_MAG_W      = 27;
	localparam int IMM_W         = 8;
	localparam int SHAMT_W       = 6;

	// Flag register after reset: only the always-set bit.
	localparam logic [FLAGS_W-1:0] FLAGS_RESET = 7'd64;

	// Flag bit positions.
	localparam int FLAG_ALWAYS = 6;
	localparam int FLAG_EQ     = 5;
	localparam int FLAG_NE     = 4;
	localparam int FLAG_LE     = 3;
	localparam int FLAG_GE     = 2;
	localparam int FLAG_LT     = 1;
	localparam int FLAG_GT     = 0;

	// Top nibble range of the conditional branches.
	localparam logic [3:0] BR_FIRST = 4'h8;
	localparam logic [3:0] BR_LAST  = 4'hE;
	localparam logic [3:0] TOP_ALU  = 4'h0;

	// ALU operation codes (top nibble of byte 1).
	typedef enum logic [3:0] {
		OP_AND = 4'h0,
		OP_OR  = 4'h1,
		OP_XOR = 4'h2,
		OP_ADD = 4'h3,
		OP_ADC = 4'h4,
		OP_CMP = 4'h5,
		OP_SUB = 4'h6,
		OP_SBC = 4'h7,
		OP_MOV = 4'h8,
		OP_LSH = 4'h9,
		OP_RSH = 4'hA
	} alu_op_t;

	// Result of executing one instruction.
	typedef struct packed {
		logic [PC_WIDTH-1:0]   pc;
		logic                  reg_write;
		logic [REG_IDX_W-1:0]  write_index;
		logic [DATA_WIDTH-1:0] write_value;
		logic [FLAGS_W-1:0]    flags;
		logic                  illegal;
	} exec_res_t;

endpackage

@@ design/tce_exec.sv @@
// ----------------------------------------------------------------------------
// tce_exec: combinational instruction execute
// Decodes one instruction word and computes the next PC, the register write,
// the new flags and the illegal indication from the current state.
// ----------------------------------------------------------------------------
module tce_exec (
	input  logic [tce_pkg::INSTR_W-1:0]    instr,
	input  logic [tce_pkg::DATA_WIDTH-1:0] opa,
	input  logic [tce_pkg::DATA_WIDTH-1:0] opb,
	input  logic [tce_pkg::FLAGS_W-1:0]    flags_in,
	input  logic [tce_pkg::PC_WIDTH-1:0]   pc_in,
	output tce_pkg::exec_res_t             res
);
	import tce_pkg::*;

	logic [3:0]            top;
	logic                  imm_sel;
	alu_op_t               op;
	logic [IMM_W-1:0]      imm;
	logic [BR_MAG_W-1:0]   mag;
	logic                  br_neg;
	logic [3:0]            br_bit;
	logic [DATA_WIDTH-1:0] b_val;
	logic [SHAMT_W-1:0]    shamt;
	logic [PC_WIDTH-1:0]   pc_inc;
	logic [DATA_WIDTH-1:0] alu_val;
	logic                  alu_wr;
	logic                  alu_bad;
	logic [FLAGS_W-1:0]    cmp_flags;

	// Instruction fields.
	assign top     = instr[31:28];
	assign imm_sel = instr[24];
	assign op      = alu_op_t'(instr[23:20]);
	assign imm     = instr[7:0];
	assign mag     = instr[26:0];
	assign br_neg  = instr[27];
	assign br_bit  = BR_LAST - top;
	assign b_val   = imm_sel ? DATA_WIDTH'(imm) : opb;
	assign shamt   = b_val[SHAMT_W-1:0];
	assign pc_inc  = pc_in + PC_WIDTH'(1);

	// Signed compare of the two operands.
	always_comb begin
		cmp_flags              = '0;
		cmp_flags[FLAG_ALWAYS] = 1'b1;
		cmp_flags[FLAG_EQ]     = (opa == b_val);
		cmp_flags[FLAG_NE]     = (opa != b_val);
		cmp_flags[FLAG_LE]     = ($signed(opa) <= $signed(b_val));
		cmp_flags[FLAG_GE]     = ($signed(opa) >= $signed(b_val));
		cmp_flags[FLAG_LT]     = ($signed(opa) < $signed(b_val));
		cmp_flags[FLAG_GT]     = ($signed(opa) > $signed(b_val));
	end

	// ALU operation select.
	always_comb begin
		alu_val = '0;
		alu_wr  = 1'b1;
		alu_bad = 1'b0;
		case (op)
			OP_AND: alu_val = opa & b_val;
			OP_OR:  alu_val = opa | b_val;
			OP_XOR: alu_val = opa ^ b_val;
			OP_ADD: alu_val = opa + b_val;
			OP_CMP: alu_wr  = 1'b0;
			OP_SUB: alu_val = opa - b_val;
			OP_MOV: alu_val = b_val;
			OP_LSH: alu_val = opa << shamt;
			OP_RSH: alu_val = DATA_WIDTH'($signed(opa) >>> shamt);
			default: begin
				alu_wr  = 1'b0;
				alu_bad = 1'b1;
			end
		endcase
	end

	// Branch or ALU result.
	always_comb begin
		res             = '0;
		res.pc          = pc_inc;
		res.flags       = flags_in;
		if (top != TOP_ALU) begin
			if (top >= BR_FIRST && top <= BR_LAST) begin
				if (flags_in[br_bit[2:0]]) begin
					res.pc = br_neg ? pc_in - PC_WIDTH'(mag) : pc_in + PC_WIDTH'(mag);
				end
			end else begin
				res.illegal = 1'b1;
			end
		end else begin
			res.illegal = alu_bad;
			if (op == OP_CMP) begin
				res.flags = cmp_flags;
			end
			if (alu_wr) begin
				res.reg_write   = 1'b1;
				res.write_index = instr[11:8];
				res.write_value = alu_val;
			end
		end
	end

endmodule

@@ design/toy_core_instruction_execute.sv @@
// ----------------------------------------------------------------------------
// toy_core_instruction_execute: execute stage of a small 16-register core
//
//   channel   signals                                   direction
//   input     in_valid, in_ready, instruction_word      item in
//   output    out_valid, out_ready, next_pc, reg_write,  item out
//             write_index, write_value, flags_out,
//             illegal
//
// One item per cycle sustained while the output is not stalled. The operand
// read register loads on acceptance and the execute result then loads the
// result register, from which the item leaves.
// The register file is read when an item is accepted, with the write of the
// retiring item forwarded into the operand registers.
// Reset clears the PC, sets the flags to 64 and marks every register as
// holding its own index; no clearing pass is needed.
// A stalled output holds its item; the input keeps accepting until both
// stages are full.
// ----------------------------------------------------------------------------
module toy_core_instruction_execute (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [tce_pkg::INSTR_W-1:0]         instruction_word,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [tce_pkg::NEXT_PC_W-1:0]       next_pc,
	output logic                                reg_write,
	output logic [tce_pkg::REG_IDX_W-1:0]       write_index,
	output logic signed [tce_pkg::WRITE_VALUE_W-1:0] write_value,
	output logic [tce_pkg::FLAGS_W-1:0]         flags_out,
	output logic                                illegal
);
	import tce_pkg::*;

	logic                  in_fire;
	logic                  retire;
	logic                  s1_valid_q;
	logic [INSTR_W-1:0]    instr_s1;
	logic [DATA_WIDTH-1:0] opa_s1;
	logic [DATA_WIDTH-1:0] opb_s1;
	logic [REG_IDX_W-1:0]  a_idx;
	logic [REG_IDX_W-1:0]  b_idx;
	logic [PC_WIDTH-1:0]   pc_q;
	logic [FLAGS_W-1:0]    flags_q;
	logic [NUM_REGS-1:0]   rf_valid_q;
	logic [DATA_WIDTH-1:0] rf_mem [NUM_REGS];
	exec_res_t             exec_res;
	exec_res_t             res_q;
	logic                  out_valid_q;

	assign retire   = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || retire;
	assign in_fire  = in_valid && in_ready;
	assign a_idx    = instruction_word[19:16];
	assign b_idx    = instruction_word[15:12];

	// Stage 1 valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	// Operand read with forwarding of the retiring write.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			instr_s1 <= instruction_word;
			if (retire && exec_res.reg_write && exec_res.write_index == a_idx) begin
				opa_s1 <= exec_res.write_value;
			end else begin
				opa_s1 <= rf_valid_q[a_idx] ? rf_mem[a_idx] : DATA_WIDTH'(a_idx);
			end
			if (retire && exec_res.reg_write && exec_res.write_index == b_idx) begin
				opb_s1 <= exec_res.write_value;
			end else begin
				opb_s1 <= rf_valid_q[b_idx] ? rf_mem[b_idx] : DATA_WIDTH'(b_idx);
			end
		end
	end

	// Execute.
	tce_exec u_exec (
		.instr    (instr_s1),
		.opa      (opa_s1),
		.opb      (opb_s1),
		.flags_in (flags_q),
		.pc_in    (pc_q),
		.res      (exec_res)
	);

	// Register file storage.
	always_ff @(posedge clk) begin
		if (retire && exec_res.reg_write) begin
			rf_mem[exec_res.write_index] <= exec_res.write_value;
		end
	end

	// Architectural state: written registers, PC and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_valid_q <= '0;
			pc_q       <= '0;
			flags_q    <= FLAGS_RESET;
		end else if (retire) begin
			if (exec_res.reg_write) begin
				rf_valid_q[exec_res.write_index] <= 1'b1;
			end
			pc_q    <= exec_res.pc;
			flags_q <= exec_res.flags;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (retire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (retire) begin
			res_q <= exec_res;
		end
	end

	assign out_valid   = out_valid_q;
	assign next_pc     = NEXT_PC_W'(res_q.pc);
	assign reg_write   = res_q.reg_write;
	assign write_index = res_q.write_index;
	assign write_value = WRITE_VALUE_W'($signed(res_q.write_value));
	assign flags_out   = res_q.flags;
	assign illegal     = res_q.illegal;

	// An empty operand stage always takes a new item.
	a_s1_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_q |-> in_ready)
		else $error("operand stage empty but input not ready");

	// A retiring item shows up in the result register next cycle.
	a_retire_out: assert property (@(posedge clk) disable iff (!arst_n)
		retire |=> out_valid_q)
		else $error("retired item missing from result register");

	// Illegal instructions never write a register.
	a_illegal_nowrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(reg_write && illegal))
		else $error("illegal instruction wrote a register");

	// No write means zero index and value.
	a_nowrite_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !reg_write |-> (write_index == '0) && (write_value == '0))
		else $error("write fields nonzero without a write");

	// The always-set flag stays set.
	a_flag_always: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> flags_out[FLAG_ALWAYS])
		else $error("always-set flag cleared");

endmodule
